/* rtl/bbms_pkg.sv */
// ----------------------------------------------------------------------------
// bbms_pkg
// Shared types and constants of the bilinear bump map sampler.
// ----------------------------------------------------------------------------
package bbms_pkg;

    localparam int MAX_MAP_WIDTH   = 256;
    localparam int MAX_MAP_HEIGHT  = 256;
    localparam int COORD_FRAC_BITS = 16;
    localparam int WEIGHT_BITS     = 8;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int POS_FRAC_BITS   = COORD_FRAC_BITS + SCALE_FRAC_BITS;

    localparam int COORD_W   = 24;
    localparam int SCALE_W   = 16;
    localparam int SIZE_W    = 9;
    localparam int IDX_W     = 8;
    localparam int ADDR_W    = 16;
    localparam int TEXEL_W   = 8;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_U    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_V    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd3;

    // one queued word: texel write or sample with its four read addresses
    typedef struct packed {
        logic                         cmd;
        logic [3:0][ADDR_W-1:0]       addr;
        logic [TEXEL_W-1:0]           value;
        logic [WEIGHT_BITS-1:0]       fx;
        logic [WEIGHT_BITS-1:0]       fy;
    } t_bbms_entry;

    typedef struct packed {
        logic [IDX_W-1:0]       lo;
        logic [IDX_W-1:0]       hi;
        logic [WEIGHT_BITS-1:0] wt;
    } t_bbms_axis;

endpackage

/* rtl/bbms_ram.sv */
// ----------------------------------------------------------------------------
// bbms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/bbms_front.sv */
// ----------------------------------------------------------------------------
// bbms_front
// Accepts words, wraps and splits coordinates, forms texel addresses.
// ----------------------------------------------------------------------------
module bbms_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic signed [bbms_pkg::COORD_W-1:0] i_u_coord,
    input  logic signed [bbms_pkg::COORD_W-1:0] i_v_coord,
    input  logic [bbms_pkg::ADDR_W-1:0]       i_texel_address,
    input  logic [bbms_pkg::TEXEL_W-1:0]      i_texel_value,
    input  logic [bbms_pkg::SCALE_W-1:0]      i_scale_u,
    input  logic [bbms_pkg::SCALE_W-1:0]      i_scale_v,
    input  logic [bbms_pkg::SIZE_W-1:0]       i_width,
    input  logic [bbms_pkg::SIZE_W-1:0]       i_height,
    output logic                              o_push,
    output bbms_pkg::t_bbms_entry             o_entry,
    input  logic                              i_full
);
    import bbms_pkg::*;

    localparam int PROD_W = POS_FRAC_BITS + SIZE_W;

    function automatic t_bbms_axis axis_split(input logic [POS_FRAC_BITS-1:0] c,
                                              input logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] t;
        logic              neg;
        logic [SIZE_W-1:0] idx;
        logic [SIZE_W-1:0] nxt;
        logic [SIZE_W-1:0] lim;
        t_bbms_axis        r;
        prod = PROD_W'(c) * PROD_W'(size);
        // half-texel offset
        neg  = prod < (PROD_W'(1) << (POS_FRAC_BITS - 1));
        t    = prod - (PROD_W'(1) << (POS_FRAC_BITS - 1));
        lim  = size - SIZE_W'(1);
        idx  = neg ? '0 : t[PROD_W-1:POS_FRAC_BITS];
        nxt  = neg ? '0 : idx + SIZE_W'(1);
        if (idx > lim) idx = lim;
        if (nxt > lim) nxt = lim;
        r.lo = idx[IDX_W-1:0];
        r.hi = nxt[IDX_W-1:0];
        r.wt = t[POS_FRAC_BITS-1 -: WEIGHT_BITS];
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] lin_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col,
                                                   input logic [SIZE_W-1:0] w);
        logic [IDX_W+SIZE_W:0] a;
        a = (IDX_W+SIZE_W+1)'(row) * (IDX_W+SIZE_W+1)'(w) + (IDX_W+SIZE_W+1)'(col);
        return a[ADDR_W-1:0];
    endfunction

    logic f_en;
    logic accept;

    // stage 1: wrap
    logic                     r_s1_v;
    logic                     r_s1_cmd;
    logic [POS_FRAC_BITS-1:0] r_s1_cu;
    logic [POS_FRAC_BITS-1:0] r_s1_cv;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic [TEXEL_W-1:0]       r_s1_value;
    logic [COORD_W+SCALE_W-1:0] prod_u;
    logic [COORD_W+SCALE_W-1:0] prod_v;

    // stage 2: index and weight
    logic              r_s2_v;
    logic              r_s2_cmd;
    t_bbms_axis        r_s2_x;
    t_bbms_axis        r_s2_y;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [TEXEL_W-1:0] r_s2_value;

    // stage 3: addresses
    logic        r_s3_v;
    t_bbms_entry r_s3;
    t_bbms_entry n_s3;

    assign f_en    = !r_s3_v || !i_full;
    assign o_stall = !f_en;
    assign accept  = i_valid && f_en;
    assign o_push  = r_s3_v && f_en;
    assign o_entry = r_s3;

    assign prod_u = (COORD_W+SCALE_W)'($unsigned(i_u_coord)) * (COORD_W+SCALE_W)'(i_scale_u);
    assign prod_v = (COORD_W+SCALE_W)'($unsigned(i_v_coord)) * (COORD_W+SCALE_W)'(i_scale_v);

    always_comb begin
        n_s3       = '0;
        n_s3.cmd   = r_s2_cmd;
        n_s3.value = r_s2_value;
        n_s3.fx    = r_s2_x.wt;
        n_s3.fy    = r_s2_y.wt;
        if (r_s2_cmd == CMD_WRITE) begin
            n_s3.addr[0] = r_s2_addr;
        end else begin
            n_s3.addr[0] = lin_addr(r_s2_y.lo, r_s2_x.lo, i_width);
            n_s3.addr[1] = lin_addr(r_s2_y.lo, r_s2_x.hi, i_width);
            n_s3.addr[2] = lin_addr(r_s2_y.hi, r_s2_x.lo, i_width);
            n_s3.addr[3] = lin_addr(r_s2_y.hi, r_s2_x.hi, i_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (f_en) begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_s1_cmd   <= i_command;
            r_s1_cu    <= prod_u[POS_FRAC_BITS-1:0];
            r_s1_cv    <= prod_v[POS_FRAC_BITS-1:0];
            r_s1_addr  <= i_texel_address;
            r_s1_value <= i_texel_value;
            r_s2_cmd   <= r_s1_cmd;
            r_s2_x     <= axis_split(r_s1_cu, i_width);
            r_s2_y     <= axis_split(r_s1_cv, i_height);
            r_s2_addr  <= r_s1_addr;
            r_s2_value <= r_s1_value;
            r_s3       <= n_s3;
        end
    end
endmodule

/* rtl/bbms_queue.sv */
// ----------------------------------------------------------------------------
// bbms_queue
// Short word queue between the front and back halves.
// ----------------------------------------------------------------------------
module bbms_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bbms_pkg::t_bbms_entry i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output bbms_pkg::t_bbms_entry o_entry
);
    import bbms_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_bbms_entry      r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full  = r_count == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_entry;
        end
    end
endmodule

/* rtl/bbms_back.sv */
// ----------------------------------------------------------------------------
// bbms_back
// Height store writes, four texel reads and the bilinear blend.
// ----------------------------------------------------------------------------
module bbms_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  bbms_pkg::t_bbms_entry          i_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bbms_pkg::HEIGHT_W-1:0]  o_height_value
);
    import bbms_pkg::*;

    localparam int ONE_W  = WEIGHT_BITS + 1;
    localparam int ROW_W  = TEXEL_W + WEIGHT_BITS;
    localparam int ACC_W  = ROW_W + WEIGHT_BITS;
    localparam int SHIFT  = 2 * WEIGHT_BITS - 8;

    logic adv;
    logic wr_en;
    logic [3:0][TEXEL_W-1:0] texel;

    logic                   r_b1_v;
    logic [WEIGHT_BITS-1:0] r_b1_fx;
    logic [WEIGHT_BITS-1:0] r_b1_fy;
    logic                   r_b2_v;
    logic [ROW_W-1:0]       r_b2_top;
    logic [ROW_W-1:0]       r_b2_bot;
    logic [WEIGHT_BITS-1:0] r_b2_fy;
    logic                   r_out_v;
    logic [HEIGHT_W-1:0]    r_out;

    logic [ONE_W-1:0] inv_fx;
    logic [ONE_W-1:0] inv_fy;
    logic [ROW_W:0]   n_top;
    logic [ROW_W:0]   n_bot;
    logic [ACC_W:0]   n_acc;

    assign adv   = !(r_out_v && i_stall);
    assign o_pop = adv && !i_empty;
    assign wr_en = o_pop && (i_entry.cmd == CMD_WRITE);

    // one copy of the store per corner, all written together
    for (genvar g = 0; g < 4; g++) begin : g_bank
        bbms_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en),
            .i_waddr (i_entry.addr[0]),
            .i_wdata (i_entry.value),
            .i_re    (adv),
            .i_raddr (i_entry.addr[g]),
            .o_rdata (texel[g])
        );
    end

    assign inv_fx = (ONE_W'(1) << WEIGHT_BITS) - ONE_W'(r_b1_fx);
    assign inv_fy = (ONE_W'(1) << WEIGHT_BITS) - ONE_W'(r_b2_fy);
    assign n_top  = (ROW_W+1)'(texel[0]) * (ROW_W+1)'(inv_fx)
                  + (ROW_W+1)'(texel[1]) * (ROW_W+1)'(r_b1_fx);
    assign n_bot  = (ROW_W+1)'(texel[2]) * (ROW_W+1)'(inv_fx)
                  + (ROW_W+1)'(texel[3]) * (ROW_W+1)'(r_b1_fx);
    assign n_acc  = (ACC_W+1)'(r_b2_top) * (ACC_W+1)'(inv_fy)
                  + (ACC_W+1)'(r_b2_bot) * (ACC_W+1)'(r_b2_fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_b1_v  <= o_pop && (i_entry.cmd == CMD_SAMPLE);
            r_b2_v  <= r_b1_v;
            r_out_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_fx  <= i_entry.fx;
            r_b1_fy  <= i_entry.fy;
            r_b2_top <= n_top[ROW_W-1:0];
            r_b2_bot <= n_bot[ROW_W-1:0];
            r_b2_fy  <= r_b1_fy;
            r_out    <= n_acc[SHIFT +: HEIGHT_W];
        end
    end

    assign o_valid        = r_out_v;
    assign o_height_value = r_out;
endmodule

/* rtl/bilinear_bump_map_sampler.sv */
// ----------------------------------------------------------------------------
// bilinear_bump_map_sampler
// Height map sampler: wrapped coordinates, clamped edges, bilinear blend.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | i_valid / o_stall   | i_command i_u_coord i_v_coord
//          |                     | i_texel_address i_texel_value
//  output  | o_valid / i_stall   | o_height_value
//  config  | i_cfg_wr_en         | i_cfg_index i_cfg_data
//
//  One word per cycle sustained while the output is not stalled. A sample
//  passes 3 front stages, the queue, the ram read, row blend, column blend.
//  The four texel reads use four copies of the height store, each with its
//  own read port. A texel write takes effect in the back half, in order.
//  An output stall freezes the back half; the queue then fills and the front
//  stalls its input. Synchronous reset clears control state only.
// ----------------------------------------------------------------------------
module bilinear_bump_map_sampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_command,
    input  logic signed [bbms_pkg::COORD_W-1:0]  i_u_coord,
    input  logic signed [bbms_pkg::COORD_W-1:0]  i_v_coord,
    input  logic [bbms_pkg::ADDR_W-1:0]          i_texel_address,
    input  logic [bbms_pkg::TEXEL_W-1:0]         i_texel_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [bbms_pkg::HEIGHT_W-1:0]        o_height_value,
    input  logic                                 i_cfg_wr_en,
    input  logic [bbms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bbms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bbms_pkg::*;

    logic [SCALE_W-1:0] r_scale_u;
    logic [SCALE_W-1:0] r_scale_v;
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [SIZE_W-1:0]  eff_width;
    logic [SIZE_W-1:0]  eff_height;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    t_bbms_entry q_in;
    t_bbms_entry q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_u <= SCALE_W'(256);
            r_scale_v <= SCALE_W'(256);
            r_width   <= SIZE_W'(256);
            r_height  <= SIZE_W'(256);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SCALE_U:    r_scale_u <= i_cfg_data;
                REG_SCALE_V:    r_scale_v <= i_cfg_data;
                REG_MAP_WIDTH:  r_width   <= i_cfg_data[SIZE_W-1:0];
                REG_MAP_HEIGHT: r_height  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    assign eff_width  = (r_width == '0) ? SIZE_W'(1) :
                        (r_width > SIZE_W'(MAX_MAP_WIDTH)) ? SIZE_W'(MAX_MAP_WIDTH) : r_width;
    assign eff_height = (r_height == '0) ? SIZE_W'(1) :
                        (r_height > SIZE_W'(MAX_MAP_HEIGHT)) ? SIZE_W'(MAX_MAP_HEIGHT) : r_height;

    bbms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_u_coord       (i_u_coord),
        .i_v_coord       (i_v_coord),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_scale_u       (r_scale_u),
        .i_scale_v       (r_scale_v),
        .i_width         (eff_width),
        .i_height        (eff_height),
        .o_push          (q_push),
        .o_entry         (q_in),
        .i_full          (q_full)
    );

    bbms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    bbms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_entry        (q_out),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_height_value (o_height_value)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_height_value)))
        else $error("stalled result lost");
endmodule

/* bench/tb_bilinear_bump_map_sampler.sv */
// ----------------------------------------------------------------------------
// tb_bilinear_bump_map_sampler
// Self-checking bench for the bilinear height map sampler. Each map region is
// loaded before it is sampled. A local model of the store and the repeat
// factors predicts every blended height, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_bilinear_bump_map_sampler;
    import bbms_pkg::*;

    // index past the four registers, must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef struct {
        logic                      cmd;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic [ADDR_W-1:0]         addr;
        logic [TEXEL_W-1:0]        val;
    } t_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_command = CMD_WRITE;
    logic signed [COORD_W-1:0] i_u_coord = '0;
    logic signed [COORD_W-1:0] i_v_coord = '0;
    logic [ADDR_W-1:0]         i_texel_address = '0;
    logic [TEXEL_W-1:0]        i_texel_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [HEIGHT_W-1:0]       o_height_value;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    bilinear_bump_map_sampler dut (.*);

    always #5 i_clk = ~i_clk;

    t_word               pending_words[$];
    logic [HEIGHT_W-1:0] expected_heights[$];
    logic [TEXEL_W-1:0]  height_map[STORE_DEPTH];
    bit                  loaded[STORE_DEPTH];
    logic [SCALE_W-1:0]  rep_u = 256, rep_v = 256;
    logic [SIZE_W-1:0]   width_reg = 256, height_reg = 256;
    int                  errors = 0;
    bit                  quiet = 1'b0;
    int                  gap = 0;
    int                  stall_cnt = 0;
    int                  hold_reqs = 0;
    int                  hold_seen = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int usable_size(logic [SIZE_W-1:0] reg_val, int max_size);
        if (reg_val < 1) return 1;
        if (reg_val > max_size) return max_size;
        return reg_val;
    endfunction

    // wrap, move to texel space with half-texel offset, split index/weight
    task automatic split_axis(input logic signed [COORD_W-1:0] coord,
                              input logic [SCALE_W-1:0] rep, input int size,
                              output int lo, output int hi,
                              output logic [WEIGHT_BITS-1:0] wt);
        longint prod, t, fr;
        longint fmask;
        fmask = (longint'(1) << POS_FRAC_BITS) - 1;
        prod = (longint'(coord) * longint'(rep)) & fmask;
        t = prod * size - (longint'(1) << (POS_FRAC_BITS - 1));
        if (t < 0) begin
            lo = -1;
            fr = t + (longint'(1) << POS_FRAC_BITS);
        end else begin
            lo = int'(t >>> POS_FRAC_BITS);
            fr = t & fmask;
        end
        hi = lo + 1;
        if (hi > size - 1) hi = size - 1;
        if (lo > size - 1) lo = size - 1;
        if (lo < 0) lo = 0;
        wt = WEIGHT_BITS'(fr >> (POS_FRAC_BITS - WEIGHT_BITS));
    endtask

    function automatic longint texel_at(int row, int col, int w);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row * w + col);
        return longint'(height_map[a]);
    endfunction

    // apply one accepted word to the local map, or compute its blended height
    task automatic blend_height(input t_word wd);
        int w, h, x0, x1, y0, y1;
        logic [WEIGHT_BITS-1:0] fx, fy;
        longint one, top, bot, acc;
        one = longint'(1) << WEIGHT_BITS;
        if (wd.cmd == CMD_WRITE) begin
            height_map[wd.addr] = wd.val;
        end else begin
            w = usable_size(width_reg, MAX_MAP_WIDTH);
            h = usable_size(height_reg, MAX_MAP_HEIGHT);
            split_axis(wd.u, rep_u, w, x0, x1, fx);
            split_axis(wd.v, rep_v, h, y0, y1, fy);
            top = texel_at(y0, x0, w) * (one - fx) + texel_at(y0, x1, w) * fx;
            bot = texel_at(y1, x0, w) * (one - fx) + texel_at(y1, x1, w) * fx;
            acc = top * (one - fy) + bot * fy;
            expected_heights.push_back(HEIGHT_W'(acc >> (2 * WEIGHT_BITS - 8)));
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_word nx;
        t_word cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                cur.cmd = i_command; cur.u = i_u_coord; cur.v = i_v_coord;
                cur.addr = i_texel_address; cur.val = i_texel_value;
                blend_height(cur);
            end
            if (!i_valid || !o_stall) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    nx = pending_words.pop_front();
                    i_command <= nx.cmd;
                    i_u_coord <= nx.u;
                    i_v_coord <= nx.v;
                    i_texel_address <= nx.addr;
                    i_texel_value <= nx.val;
                    i_valid <= 1'b1;
                    gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check results, then choose the next stall
    always @(posedge i_clk) begin
        logic [HEIGHT_W-1:0] exp_h;
        int r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_heights.size() == 0) begin
                $error("unexpected height_value %0d", o_height_value);
                errors++;
            end else begin
                exp_h = expected_heights.pop_front();
                if (o_height_value !== exp_h) begin
                    $error("height_value expected %0d actual %0d", exp_h, o_height_value);
                    errors++;
                end
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            stall_cnt = 120;
            i_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (quiet || r < 70) begin
                i_stall <= 1'b0;
            end else begin
                stall_cnt = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                i_stall <= 1'b1;
            end
        end
    end

    task automatic push_write(input logic [ADDR_W-1:0] a, input logic [TEXEL_W-1:0] v);
        t_word wd;
        wd.cmd = CMD_WRITE; wd.addr = a; wd.val = v;
        wd.u = COORD_W'($urandom); wd.v = COORD_W'($urandom);
        loaded[a] = 1'b1;
        pending_words.push_back(wd);
    endtask

    task automatic push_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        t_word wd;
        wd.cmd = CMD_SAMPLE; wd.u = u; wd.v = v;
        wd.addr = ADDR_W'($urandom); wd.val = TEXEL_W'($urandom);
        pending_words.push_back(wd);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
            3: return COORD_W'(-$urandom_range(0, 1 << COORD_FRAC_BITS));
            4: return COORD_W'($urandom_range(0, 255) << (COORD_FRAC_BITS - 8));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_valid || expected_heights.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        case (idx)
            REG_SCALE_U:    rep_u = SCALE_W'(data);
            REG_SCALE_V:    rep_v = SCALE_W'(data);
            REG_MAP_WIDTH:  width_reg = SIZE_W'(data);
            REG_MAP_HEIGHT: height_reg = SIZE_W'(data);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // set up one phase and make sure every reachable entry is loaded
    task automatic start_phase(input int su, input int sv, input int w, input int h);
        int span;
        wait_idle();
        cfg_write(REG_SCALE_U, su);
        cfg_write(REG_SCALE_V, sv);
        cfg_write(REG_MAP_WIDTH, w);
        cfg_write(REG_MAP_HEIGHT, h);
        span = usable_size(SIZE_W'(w), MAX_MAP_WIDTH) * usable_size(SIZE_W'(h), MAX_MAP_HEIGHT);
        for (int a = 0; a < span; a++)
            if (!loaded[a]) push_write(ADDR_W'(a), TEXEL_W'($urandom));
    endtask

    task automatic random_items(input int n, input int span);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 70)
                push_sample(pick_coord(), pick_coord());
            else if ($urandom_range(0, 1) == 0)
                push_write(ADDR_W'($urandom_range(0, span - 1)), TEXEL_W'($urandom));
            else
                push_write(ADDR_W'($urandom), TEXEL_W'($urandom));
        end
    endtask

    initial begin
        int w, h;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small map, extremes of the coordinates and values
        cfg_write(REG_UNUSED, 16'hFFFF);
        start_phase(256, 256, 4, 4);
        push_write(16'hFFFF, 8'hFF);
        push_write(16'h0000, 8'h00);
        push_write(16'h0005, 8'hFF);
        push_sample(24'h000000, 24'h000000);
        push_sample(24'h7FFFFF, 24'h7FFFFF);
        push_sample(24'h800000, 24'h800000);
        push_sample(24'h008000, 24'h008000);
        push_sample(24'h004000, 24'h00C000);
        push_sample(24'hFFFFFF, 24'h000001);
        push_sample(24'h002000, 24'h002000);
        push_sample(24'h00FFFF, 24'h00E000);
        push_write(16'h000F, 8'hFF);
        push_sample(24'h00FFFF, 24'h00FFFF);
        random_items(150, 16);

        // zero scale, then the largest scale with the receiver holding off
        start_phase(0, 0, 3, 5);
        random_items(40, 15);
        start_phase(65535, 65535, 7, 2);
        hold_reqs++;
        random_items(150, 14);

        // size of zero taken as one, sizes past the maximum saturate
        start_phase(256, 256, 0, 0);
        random_items(40, 1);
        start_phase(384, 128, 511, 2);
        random_items(160, 512);
        start_phase(256, 512 & 16'hFFFF, 1, 300);
        random_items(160, 256);

        for (int p = 0; p < 6; p++) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
            start_phase($urandom_range(0, 65535), $urandom_range(0, 1024), w, h);
            quiet = (p == 2);
            random_items(40, w * h);
            if (p == 3) wait_idle();
            random_items(40, w * h);
        end
        quiet = 1'b0;

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("bilinear_bump_map_sampler regression: pass");
        else
            $display("bilinear_bump_map_sampler regression: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("bilinear_bump_map_sampler regression: fail");
        $finish;
    end

endmodule
